/* rtl/fxa_pkg.sv */
// Shared definitions for the fixed-point ALU: command codes.
// No dependencies.
`default_nettype none
package fxa_pkg;

  typedef enum logic [3:0] {
    CMD_ADD     = 4'd0,
    CMD_SUB     = 4'd1,
    CMD_MUL     = 4'd2,
    CMD_DIV     = 4'd3,
    CMD_GT      = 4'd4,
    CMD_LT      = 4'd5,
    CMD_GE      = 4'd6,
    CMD_LE      = 4'd7,
    CMD_EQ      = 4'd8,
    CMD_NE      = 4'd9,
    CMD_MAX     = 4'd10,
    CMD_MIN     = 4'd11,
    CMD_INC     = 4'd12,
    CMD_DEC     = 4'd13,
    CMD_TOINT   = 4'd14,
    CMD_FROMINT = 4'd15
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/fxa_div_stage.sv */
// One registered step of the restoring divider: one quotient bit per stage.
// Depends on nothing.
`default_nettype none
module fxa_div_stage #(
  parameter int NW = 40,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic [DW-1:0] rem_in,
  input  logic [NW-1:0] nq_in,
  input  logic [DW-1:0] den,
  output logic [DW-1:0] rem_out,
  output logic [NW-1:0] nq_out
);

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  assign trial = {rem_in, nq_in[NW-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    rem_out <= ge ? diff[DW-1:0] : trial[DW-1:0];
    nq_out  <= {nq_in[NW-2:0], ge};
  end

endmodule
`default_nettype wire

/* rtl/fixed_point_q24_8_alu_top.sv */
// Top level of the signed fixed-point ALU (Q24.8 by default).
// Depends on fxa_pkg and fxa_div_stage.
`default_nettype none
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   busy never rises: the block is fully pipelined and takes one request
//   every cycle, whatever the command.
//   Each request gives exactly one result, shown for one cycle with done
//   high. Results come out in request order.
//   Latency is the same for every command, for Q24.8 and other formats.
//   It is set by the divider, a chain of WORD_BITS + FRAC_BITS registered
//   compare/subtract stages, one quotient bit each; other commands ride a
//   matching delay line beside it.
//   Stages: operand register, magnitude/compare/multiply, then the divider
//   chain (the multiply result is finished in its first stage), then the
//   output register.
//   Reset (rst, synchronous) clears every valid bit, dropping requests in
//   flight; data registers are not reset.
//   The receiver cannot stall: done lasts one cycle and must be taken.
//   Divide by zero gives result_value 0 with divide_by_zero set.
module fixed_point_q24_8_alu_top #(
  parameter int FRAC_BITS = 8,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         command,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               done,
  output logic signed [31:0] result_value,
  output logic               compare_true,
  output logic               divide_by_zero
);

  localparam int W  = WORD_BITS;
  localparam int NW = WORD_BITS + FRAC_BITS; // quotient bits = divider stages

  assign busy = 1'b0;

  // stage 1: operand register
  logic                v1;
  fxa_pkg::cmd_t       cmd1;
  logic signed [W-1:0] a1;
  logic signed [W-1:0] b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    cmd1 <= fxa_pkg::cmd_t'(command);
    a1   <= operand_a[W-1:0];
    b1   <= operand_b[W-1:0];
  end

  // stage 2: magnitudes, product, simple ops, compares
  logic                v2;
  fxa_pkg::cmd_t       cmd2;
  logic [W-1:0]        ma2;
  logic [W-1:0]        mb2;
  logic                neg2;
  logic [2*W-1:0]      prod2;
  logic [W-1:0]        alu2;
  logic                cmp2;
  logic                dz2;

  logic [W-1:0]        ma_next;
  logic [W-1:0]        mb_next;
  logic [W-1:0]        alu_next;
  logic                cmp_next;

  assign ma_next = a1[W-1] ? W'(-a1) : W'(a1);
  assign mb_next = b1[W-1] ? W'(-b1) : W'(b1);

  always_comb begin
    alu_next = '0;
    cmp_next = 1'b0;
    case (cmd1)
      fxa_pkg::CMD_ADD:     alu_next = W'(a1 + b1);
      fxa_pkg::CMD_SUB:     alu_next = W'(a1 - b1);
      fxa_pkg::CMD_GT:      cmp_next = a1 > b1;
      fxa_pkg::CMD_LT:      cmp_next = a1 < b1;
      fxa_pkg::CMD_GE:      cmp_next = a1 >= b1;
      fxa_pkg::CMD_LE:      cmp_next = a1 <= b1;
      fxa_pkg::CMD_EQ:      cmp_next = a1 == b1;
      fxa_pkg::CMD_NE:      cmp_next = a1 != b1;
      fxa_pkg::CMD_MAX:     alu_next = (a1 > b1) ? a1 : b1;
      fxa_pkg::CMD_MIN:     alu_next = (a1 < b1) ? a1 : b1;
      fxa_pkg::CMD_INC:     alu_next = W'(a1 + W'(1));
      fxa_pkg::CMD_DEC:     alu_next = W'(a1 - W'(1));
      fxa_pkg::CMD_TOINT:   alu_next = W'(a1 >>> FRAC_BITS);
      fxa_pkg::CMD_FROMINT: alu_next = W'(a1 <<< FRAC_BITS);
      default:              alu_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    cmd2  <= cmd1;
    ma2   <= ma_next;
    mb2   <= mb_next;
    neg2  <= a1[W-1] ^ b1[W-1];
    prod2 <= (2*W)'(ma_next) * (2*W)'(mb_next);
    alu2  <= alu_next;
    cmp2  <= cmp_next;
    dz2   <= (b1 == '0);
  end

  // stages 3 .. NW+2: divider chain with side delay line
  logic [W-1:0]  mul_mag;
  logic [W-1:0]  res_s3;
  logic [W-1:0]  rem   [NW];
  logic [NW-1:0] nq    [NW];
  logic [W-1:0]  dden  [NW];
  logic          sv    [NW];
  fxa_pkg::cmd_t scmd  [NW];
  logic [W-1:0]  sres  [NW];
  logic          scmp  [NW];
  logic          sdz   [NW];
  logic          sneg  [NW];

  assign mul_mag = W'(prod2 >> FRAC_BITS);
  assign res_s3  = (cmd2 == fxa_pkg::CMD_MUL) ? (neg2 ? W'(-mul_mag) : mul_mag) : alu2;

  fxa_div_stage #(.NW(NW), .DW(W)) u_div0 (
    .clk     (clk),
    .rem_in  ('0),
    .nq_in   (NW'(ma2) << FRAC_BITS),
    .den     (mb2),
    .rem_out (rem[0]),
    .nq_out  (nq[0])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dden[0] <= mb2;
    scmd[0] <= cmd2;
    sres[0] <= res_s3;
    scmp[0] <= cmp2;
    sdz[0]  <= dz2 && (cmd2 == fxa_pkg::CMD_DIV);
    sneg[0] <= neg2;
  end

  for (genvar k = 1; k < NW; k++) begin : g_div
    fxa_div_stage #(.NW(NW), .DW(W)) u_div (
      .clk     (clk),
      .rem_in  (rem[k-1]),
      .nq_in   (nq[k-1]),
      .den     (dden[k-1]),
      .rem_out (rem[k]),
      .nq_out  (nq[k])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k] <= 1'b0;
      end else begin
        sv[k] <= sv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      dden[k] <= dden[k-1];
      scmd[k] <= scmd[k-1];
      sres[k] <= sres[k-1];
      scmp[k] <= scmp[k-1];
      sdz[k]  <= sdz[k-1];
      sneg[k] <= sneg[k-1];
    end
  end

  // output register
  logic [W-1:0]        qw;
  logic signed [W-1:0] fin;

  assign qw = nq[NW-1][W-1:0];

  always_comb begin
    if (scmd[NW-1] == fxa_pkg::CMD_DIV) begin
      fin = sdz[NW-1] ? '0 : (sneg[NW-1] ? W'(-qw) : qw);
    end else begin
      fin = sres[NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sv[NW-1];
    end
  end

  always_ff @(posedge clk) begin
    result_value   <= 32'(fin);
    compare_true   <= scmp[NW-1];
    divide_by_zero <= sdz[NW-1];
  end

`ifndef ASSERT_OFF
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    done && divide_by_zero |-> result_value == 32'sd0)
    else $error("divide by zero with nonzero result");
  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    done && compare_true |-> result_value == 32'sd0)
    else $error("compare with nonzero result");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(compare_true && divide_by_zero))
    else $error("compare and divide flags both set");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("request refused");
`endif

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the Q24.8 fixed-point ALU: directed table, then random requests.
// Depends on fxa_pkg and fixed_point_q24_8_alu_top; a local predictor supplies every result not typed into a row.
module testbench;

  localparam int FRAC = 8;
  localparam int LATENCY = 42;
  localparam int RANDOM_REQUESTS = 1850;

  typedef struct packed {
    logic signed [31:0] value;
    logic               cmp;
    logic               dz;
  } alu_result_t;

  typedef struct {
    fxa_pkg::cmd_t      cmd;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               typed;  // expected value written into the row
    alu_result_t        want;
  } vector_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [3:0]         command = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic               done;
  logic signed [31:0] result_value;
  logic               compare_true;
  logic               divide_by_zero;

  alu_result_t pending_results[$];
  int          mismatches = 0;
  bit          finished = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fixed_point_q24_8_alu_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .operand_a(operand_a), .operand_b(operand_b), .done(done),
    .result_value(result_value), .compare_true(compare_true),
    .divide_by_zero(divide_by_zero)
  );

  // Sign-and-magnitude on 64 bits, so mul and div stay exact before the wrap.
  function automatic alu_result_t alu_predict(fxa_pkg::cmd_t cmd, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t r;
    logic signed [63:0] sa, sb;
    logic [63:0] ma, mb, q;
    logic neg;
    sa = 64'(a);
    sb = 64'(b);
    ma = sa < 0 ? -sa : sa;
    mb = sb < 0 ? -sb : sb;
    neg = (a < 0) != (b < 0);
    r = '0;
    case (cmd)
      fxa_pkg::CMD_ADD: r.value = a + b;
      fxa_pkg::CMD_SUB: r.value = a - b;
      fxa_pkg::CMD_MUL: begin
        q = (ma * mb) >> FRAC;
        r.value = 32'(neg ? -q : q);
      end
      fxa_pkg::CMD_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          q = (ma << FRAC) / mb;
          r.value = 32'(neg ? -q : q);
        end
      end
      fxa_pkg::CMD_GT: r.cmp = a > b;
      fxa_pkg::CMD_LT: r.cmp = a < b;
      fxa_pkg::CMD_GE: r.cmp = a >= b;
      fxa_pkg::CMD_LE: r.cmp = a <= b;
      fxa_pkg::CMD_EQ: r.cmp = a == b;
      fxa_pkg::CMD_NE: r.cmp = a != b;
      fxa_pkg::CMD_MAX: r.value = a > b ? a : b;
      fxa_pkg::CMD_MIN: r.value = a < b ? a : b;
      fxa_pkg::CMD_INC: r.value = 32'(a + 1);
      fxa_pkg::CMD_DEC: r.value = 32'(a - 1);
      fxa_pkg::CMD_TOINT: r.value = a >>> FRAC;
      default: r.value = a << FRAC;
    endcase
    return r;
  endfunction

  // Operands lean on edge values now and then so wrap and sign paths get hit.
  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(32'($urandom_range(0, 4))) - 2;
      3: return $signed(32'($urandom_range(0, 2047))) - 1024;
      default: return $signed($urandom);
    endcase
  endfunction

  // One request: optional gap, then hold start until accepted.
  task automatic issue_request(fxa_pkg::cmd_t cmd, logic signed [31:0] a,
                               logic signed [31:0] b, alu_result_t want);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(want);
    @(negedge clk);
  endtask

  // Stimulus: directed rows first, typed-in expectations where obvious.
  initial begin
    vector_t rows[$];
    alu_result_t zero_r;
    fxa_pkg::cmd_t cmd;
    logic signed [31:0] a, b;
    zero_r = '0;
    rows = '{
      '{fxa_pkg::CMD_ADD, 32'sh7fff_ffff, 32'sh1, 1, '{32'sh8000_0000, 1'b0, 1'b0}},
      '{fxa_pkg::CMD_SUB, 32'sh8000_0000, 32'sh1, 1, '{32'sh7fff_ffff, 1'b0, 1'b0}},
      '{fxa_pkg::CMD_MUL, 32'sh100, 32'sh100, 1, '{32'sh100, 1'b0, 1'b0}},
      '{fxa_pkg::CMD_MUL, -32'sh1, 32'sh1, 1, '{32'sh0, 1'b0, 1'b0}},
      '{fxa_pkg::CMD_MUL, 32'sh8000_0000, 32'sh8000_0000, 0, zero_r},
      '{fxa_pkg::CMD_MUL, 32'sh7fff_ffff, 32'sh8000_0000, 0, zero_r},
      '{fxa_pkg::CMD_DIV, 32'sh1234, 32'sh0, 1, '{32'sh0, 1'b0, 1'b1}},
      '{fxa_pkg::CMD_DIV, 32'sh8000_0000, -32'sh100, 1, '{32'sh8000_0000, 1'b0, 1'b0}},
      '{fxa_pkg::CMD_DIV, 32'sh8000_0000, -32'sh1, 0, zero_r},
      '{fxa_pkg::CMD_DIV, -32'sh7, 32'sh200, 0, zero_r},
      '{fxa_pkg::CMD_DIV, 32'sh7fff_ffff, 32'sh1, 0, zero_r},
      '{fxa_pkg::CMD_GT, 32'sh8000_0000, 32'sh7fff_ffff, 1, '{32'sh0, 1'b0, 1'b0}},
      '{fxa_pkg::CMD_LT, 32'sh8000_0000, 32'sh7fff_ffff, 1, '{32'sh0, 1'b1, 1'b0}},
      '{fxa_pkg::CMD_GE, 32'sh5, 32'sh5, 1, '{32'sh0, 1'b1, 1'b0}},
      '{fxa_pkg::CMD_LE, 32'sh6, 32'sh5, 1, '{32'sh0, 1'b0, 1'b0}},
      '{fxa_pkg::CMD_EQ, -32'sh1, -32'sh1, 1, '{32'sh0, 1'b1, 1'b0}},
      '{fxa_pkg::CMD_NE, -32'sh1, -32'sh1, 1, '{32'sh0, 1'b0, 1'b0}},
      '{fxa_pkg::CMD_MAX, 32'sh8000_0000, 32'sh7fff_ffff, 1,
        '{32'sh7fff_ffff, 1'b0, 1'b0}},
      '{fxa_pkg::CMD_MIN, 32'sh8000_0000, 32'sh7fff_ffff, 1,
        '{32'sh8000_0000, 1'b0, 1'b0}},
      '{fxa_pkg::CMD_MAX, 32'sh42, 32'sh42, 1, '{32'sh42, 1'b0, 1'b0}},
      '{fxa_pkg::CMD_INC, 32'sh7fff_ffff, 32'sh0, 1, '{32'sh8000_0000, 1'b0, 1'b0}},
      '{fxa_pkg::CMD_DEC, 32'sh8000_0000, -32'sh1, 1, '{32'sh7fff_ffff, 1'b0, 1'b0}},
      '{fxa_pkg::CMD_TOINT, -32'sh1, 32'sh0, 1, '{-32'sh1, 1'b0, 1'b0}},
      '{fxa_pkg::CMD_TOINT, 32'sh7fff_ffff, 32'sh0, 1, '{32'sh007f_ffff, 1'b0, 1'b0}},
      '{fxa_pkg::CMD_FROMINT, 32'sh0080_0001, 32'sh0, 1, '{32'sh8000_0100, 1'b0, 1'b0}}
    };
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i])
      issue_request(rows[i].cmd, rows[i].a, rows[i].b,
                    rows[i].typed ? rows[i].want : alu_predict(rows[i].cmd, rows[i].a, rows[i].b));
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      cmd = fxa_pkg::cmd_t'($urandom_range(0, 15));
      a = pick_operand();
      // a sprinkle of zero divisors and equal operands
      b = $urandom_range(0, 9) == 0 ? 32'sh0 : ($urandom_range(0, 9) == 0 ? a : pick_operand());
      issue_request(cmd, a, b, alu_predict(cmd, a, b));
    end
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    finished = 1;
  end

  // Result checker: done is a one-cycle strobe, taken at the rising edge.
  always @(posedge clk) begin
    alu_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result_value);
      end else begin
        want = pending_results.pop_front();
        if (result_value !== want.value || compare_true !== want.cmp ||
            divide_by_zero !== want.dz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want %h/%b/%b got %h/%b/%b", want.value, want.cmp,
                     want.dz, result_value, compare_true, divide_by_zero);
        end
      end
    end
  end

  initial begin
    wait (finished);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("fixed_point_q24_8_alu_top verification clean");
    end else begin
      $display("fixed_point_q24_8_alu_top verification failed");
    end
    $finish;
  end

  // Watchdog: bounds ~1900 requests, each with its random gap, plus drain.
  initial begin
    #2000000;
    $display("fixed_point_q24_8_alu_top verification failed");
    $finish;
  end
endmodule
